@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mrst_pkg.sv @@
`default_nettype none

package mrst_pkg;

    // Request field widths
    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 16;
    localparam int PAGE_W     = 2;
    localparam int SEGNUM_W   = 8;
    localparam int BYTE_W     = 8;

    // CPU address split: page select on top, offset below
    localparam int OFFSET_W   = 14;
    localparam int NUM_PAGES  = 4;

    localparam int SEGMENT_COUNT_DEF = 16;

    // Status codes
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RD_BYTE = 3'd0,
        CMD_WR_BYTE = 3'd1,
        CMD_RD_WORD = 3'd2,
        CMD_WR_WORD = 3'd3,
        CMD_SET_SEG = 3'd4
    } command_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_HI,
        ST_CAP_LO,
        ST_CAP_HI,
        ST_WR_HI,
        ST_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch incoming request
        logic mem_rd;    // read store at current address
        logic mem_wr;    // write store at current address
        logic use_hi;    // second byte: offset + 1, high data byte
        logic cap_lo;    // take read byte as low result byte
        logic cap_hi;    // take read byte as high result byte
        logic seg_set;   // apply set-segment request
        logic load_out;  // move result into output register
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/mapped_ram_segment_translator.sv @@
// Flow: accept in ST_IDLE, execute in ST_EXEC, respond in ST_RESP; byte reads also
//   pass ST_CAP_LO, word writes ST_WR_HI, word reads ST_RD_HI and ST_CAP_HI.
// The single-port byte store takes one byte per cycle and the controller runs one
//   request at a time; ST_RESP waits until the output register is free.
// Reset: asynchronous, active low; page registers return to segments 3,2,1,0
//   (modulo segment count), store contents are left as they are.
`default_nettype none

`include "assert_macros.svh"

module mapped_ram_segment_translator
#(
    parameter int SEGMENT_COUNT = mrst_pkg::SEGMENT_COUNT_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [mrst_pkg::CMD_W-1:0]       command,
    input  wire logic [mrst_pkg::ADDR_W-1:0]      address,
    input  wire logic [mrst_pkg::DATA_W-1:0]      write_data,
    input  wire logic [mrst_pkg::PAGE_W-1:0]      page,
    input  wire logic [mrst_pkg::SEGNUM_W-1:0]    segment,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [mrst_pkg::DATA_W-1:0]      read_data,
    output logic                                  status
);

    mrst_pkg::ctrl_t      ctrl;
    mrst_pkg::dp_status_t dp_stat;

    mrst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_stat   (dp_stat),
        .ctrl      (ctrl)
    );

    mrst_datapath
    #(
        .SEGMENT_COUNT (SEGMENT_COUNT)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .dp_stat    (dp_stat),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .page       (page),
        .segment    (segment),
        .read_data  (read_data),
        .status     (status)
    );

    // Checks
    `ASSERT_IMPL(a_port_conflict, ctrl.mem_rd, !ctrl.mem_wr, "store read and write together")
    `ASSERT_IMPL(a_out_overwrite, ctrl.load_out, !out_valid || out_ready, "result overwritten")
    `ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

`default_nettype wire

@@ rtl/core/mrst_ctrl.sv @@
`default_nettype none

module mrst_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire mrst_pkg::dp_status_t dp_stat,
    output mrst_pkg::ctrl_t          ctrl
);

    mrst_pkg::state_t state_reg;
    mrst_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrst_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            mrst_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.capture = in_valid;
                if (in_valid)
                begin
                    state_next = mrst_pkg::ST_EXEC;
                end
            end
            mrst_pkg::ST_EXEC:
            begin
                unique case (dp_stat.cmd)
                    mrst_pkg::CMD_RD_BYTE:
                    begin
                        ctrl.mem_rd = 1'b1;
                        state_next  = mrst_pkg::ST_CAP_LO;
                    end
                    mrst_pkg::CMD_RD_WORD:
                    begin
                        ctrl.mem_rd = 1'b1;
                        state_next  = mrst_pkg::ST_RD_HI;
                    end
                    mrst_pkg::CMD_WR_BYTE:
                    begin
                        ctrl.mem_wr = 1'b1;
                        state_next  = mrst_pkg::ST_RESP;
                    end
                    mrst_pkg::CMD_WR_WORD:
                    begin
                        ctrl.mem_wr = 1'b1;
                        state_next  = mrst_pkg::ST_WR_HI;
                    end
                    mrst_pkg::CMD_SET_SEG:
                    begin
                        ctrl.seg_set = 1'b1;
                        state_next   = mrst_pkg::ST_RESP;
                    end
                    default:
                    begin
                        // unused codes: plain done
                        state_next = mrst_pkg::ST_RESP;
                    end
                endcase
            end
            mrst_pkg::ST_RD_HI:
            begin
                // low byte lands now, fetch the high one
                ctrl.cap_lo = 1'b1;
                ctrl.mem_rd = 1'b1;
                ctrl.use_hi = 1'b1;
                state_next  = mrst_pkg::ST_CAP_HI;
            end
            mrst_pkg::ST_CAP_LO:
            begin
                ctrl.cap_lo = 1'b1;
                state_next  = mrst_pkg::ST_RESP;
            end
            mrst_pkg::ST_CAP_HI:
            begin
                ctrl.cap_hi = 1'b1;
                state_next  = mrst_pkg::ST_RESP;
            end
            mrst_pkg::ST_WR_HI:
            begin
                ctrl.mem_wr = 1'b1;
                ctrl.use_hi = 1'b1;
                state_next  = mrst_pkg::ST_RESP;
            end
            mrst_pkg::ST_RESP:
            begin
                // wait for output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = mrst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrst_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/mrst_datapath.sv @@
`default_nettype none

module mrst_datapath
#(
    parameter int SEGMENT_COUNT = mrst_pkg::SEGMENT_COUNT_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mrst_pkg::ctrl_t                  ctrl,
    output mrst_pkg::dp_status_t                  dp_stat,
    input  wire logic [mrst_pkg::CMD_W-1:0]       command,
    input  wire logic [mrst_pkg::ADDR_W-1:0]      address,
    input  wire logic [mrst_pkg::DATA_W-1:0]      write_data,
    input  wire logic [mrst_pkg::PAGE_W-1:0]      page,
    input  wire logic [mrst_pkg::SEGNUM_W-1:0]    segment,
    output logic      [mrst_pkg::DATA_W-1:0]      read_data,
    output logic                                  status
);

    localparam int SEG_W     = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam int MADDR_W   = SEG_W + mrst_pkg::OFFSET_W;
    localparam int MEM_DEPTH = SEGMENT_COUNT * (1 << mrst_pkg::OFFSET_W);

    // Reset segments 3,2,1,0 folded into the available segment range
    localparam logic [mrst_pkg::NUM_PAGES-1:0][SEG_W-1:0] RST_SEG = {
        SEG_W'(0),
        SEG_W'(1 % SEGMENT_COUNT),
        SEG_W'(2 % SEGMENT_COUNT),
        SEG_W'(3 % SEGMENT_COUNT)
    };

    // Latched request
    logic [mrst_pkg::CMD_W-1:0]    req_cmd_reg;
    logic [mrst_pkg::ADDR_W-1:0]   req_addr_reg;
    logic [mrst_pkg::DATA_W-1:0]   req_wdata_reg;
    logic [mrst_pkg::PAGE_W-1:0]   req_page_reg;
    logic [mrst_pkg::SEGNUM_W-1:0] req_seg_reg;

    // Page registers
    logic [SEG_W-1:0] page_seg_reg [mrst_pkg::NUM_PAGES];

    // Store and its read register
    logic [mrst_pkg::BYTE_W-1:0] mem [MEM_DEPTH];
    logic [mrst_pkg::BYTE_W-1:0] rd_q_reg;

    // Result accumulation and output register
    logic [mrst_pkg::BYTE_W-1:0] acc_lo_reg;
    logic [mrst_pkg::BYTE_W-1:0] acc_hi_reg;
    logic                        acc_status_reg;
    logic [mrst_pkg::DATA_W-1:0] read_data_reg;
    logic                        status_reg;

    logic [mrst_pkg::OFFSET_W-1:0] offset;
    logic [SEG_W-1:0]              cur_seg;
    logic [MADDR_W-1:0]            mem_addr;
    logic [mrst_pkg::BYTE_W-1:0]   wr_byte;
    logic                          seg_ok;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_cmd_reg   <= command;
            req_addr_reg  <= address;
            req_wdata_reg <= write_data;
            req_page_reg  <= page;
            req_seg_reg   <= segment;
        end
    end

    assign dp_stat.cmd = req_cmd_reg;

    // Segment number must be below the segment count
    assign seg_ok = ({1'b0, req_seg_reg} < (mrst_pkg::SEGNUM_W + 1)'(SEGMENT_COUNT));

    // Page registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mrst_pkg::NUM_PAGES; i++)
            begin
                page_seg_reg[i] <= RST_SEG[i];
            end
        end
        else if (ctrl.seg_set && seg_ok)
        begin
            page_seg_reg[req_page_reg] <= req_seg_reg[SEG_W-1:0];
        end
    end

    // Address translation; second byte wraps inside the segment
    assign offset   = ctrl.use_hi ? (req_addr_reg[mrst_pkg::OFFSET_W-1:0]
                                     + mrst_pkg::OFFSET_W'(1))
                                  : req_addr_reg[mrst_pkg::OFFSET_W-1:0];
    assign cur_seg  = page_seg_reg[req_addr_reg[mrst_pkg::ADDR_W-1 -: mrst_pkg::PAGE_W]];
    assign mem_addr = {cur_seg, offset};
    assign wr_byte  = ctrl.use_hi ? req_wdata_reg[mrst_pkg::DATA_W-1 -: mrst_pkg::BYTE_W]
                                  : req_wdata_reg[mrst_pkg::BYTE_W-1:0];

    // Store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_wr)
        begin
            mem[mem_addr] <= wr_byte;
        end
        if (ctrl.mem_rd)
        begin
            rd_q_reg <= mem[mem_addr];
        end
    end

    // Result build-up and output register
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            acc_lo_reg     <= '0;
            acc_hi_reg     <= '0;
            acc_status_reg <= mrst_pkg::STATUS_DONE;
        end
        else
        begin
            if (ctrl.cap_lo)
            begin
                acc_lo_reg <= rd_q_reg;
            end
            if (ctrl.cap_hi)
            begin
                acc_hi_reg <= rd_q_reg;
            end
            if (ctrl.seg_set && !seg_ok)
            begin
                acc_status_reg <= mrst_pkg::STATUS_REJECT;
            end
        end

        if (ctrl.load_out)
        begin
            read_data_reg <= {acc_hi_reg, acc_lo_reg};
            status_reg    <= acc_status_reg;
        end
    end

    assign read_data = read_data_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
